// File: rtl/pff_pkg.sv
// Shared types and constants for the page fault frequency policy block.
package pff_pkg;

	localparam int PAGE_IN_W = 16;
	localparam int THR_W     = 16;
	localparam int GAP_W     = 16;
	localparam int RES_W     = 5;
	localparam int FAULT_W   = 32;
	localparam logic [THR_W-1:0] THR_RESET = 16'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic hit;
		logic miss;
		logic compact;
		logic compact_done;
		logic finish;
	} pff_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;
		logic at_end;
		logic evict_needed;
	} pff_status_t;

endpackage

// File: rtl/page_fault_frequency_policy.sv
// Top level of the page fault frequency replacement policy.
//
// Input: raise start with page_number; the request is taken at a rising edge where
// start is high and busy is low. One result follows each request: done is high for
// exactly one cycle with fault, evicted_count, resident_count, table_full and
// fault_total, and the result must be taken in that cycle.
// Configuration: cfg_valid/cfg_ready with cfg_data writes interval_threshold;
// cfg_ready is always high. Write only while the block is idle.
// Timing: the page table is a memory walked one entry per cycle with a registered
// read. A lookup walks the entries below the occupancy; a miss that triggers
// eviction adds an in-order compaction walk before the insert. done is high in the
// first cycle with busy low, and start may already be high in that cycle, so a new
// request can be taken while the previous result is shown.
// Reset: occupancy, use bits, gap and fault counters clear, threshold goes to 2.
// The page memory is not cleared; only entries below the occupancy are read.
module page_fault_frequency_policy #(
	parameter int TABLE_DEPTH = 16,
	parameter int PAGE_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [pff_pkg::PAGE_IN_W-1:0]    page_number,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pff_pkg::THR_W-1:0]        cfg_data,
	output logic                             done,
	output logic                             fault,
	output logic [pff_pkg::RES_W-1:0]        evicted_count,
	output logic [pff_pkg::RES_W-1:0]        resident_count,
	output logic                             table_full,
	output logic [pff_pkg::FAULT_W-1:0]      fault_total
);

	pff_pkg::pff_cmd_t    cmd;
	pff_pkg::pff_status_t st;

	assign cfg_ready = 1'b1;

	pff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	pff_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PAGE_BITS   (PAGE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.page_number    (page_number),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.st             (st),
		.done           (done),
		.fault          (fault),
		.evicted_count  (evicted_count),
		.resident_count (resident_count),
		.table_full     (table_full),
		.fault_total    (fault_total)
	);

endmodule

// File: rtl/pff_ctrl.sv
// Sequencer for lookup, compaction and insert of one page request.
module pff_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pff_pkg::pff_status_t st,
	output pff_pkg::pff_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_SCAN    = 2'd1;
	localparam logic [1:0] S_COMPACT = 2'd2;
	localparam logic [1:0] S_FINISH  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.match) begin
					cmd.hit = 1'b1;
					state_d = S_IDLE;
				end else if (st.at_end) begin
					cmd.miss = 1'b1;
					state_d  = st.evict_needed ? S_COMPACT : S_FINISH;
				end
			end
			S_COMPACT: begin
				cmd.compact = 1'b1;
				if (st.at_end) begin
					cmd.compact_done = 1'b1;
					state_d          = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_hit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |-> state_q == S_SCAN && !cmd.miss)
		else $error("hit and miss together or outside scan");

	a_finish_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE)
		else $error("finish did not return to idle");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> busy)
		else $error("accepted request but not busy");

endmodule

// File: rtl/pff_datapath.sv
// Page table memory, use bits, counters and result registers.
module pff_datapath #(
	parameter int TABLE_DEPTH = 16,
	parameter int PAGE_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pff_pkg::PAGE_IN_W-1:0]    page_number,
	input  logic                             cfg_we,
	input  logic [pff_pkg::THR_W-1:0]        cfg_data,
	input  pff_pkg::pff_cmd_t                cmd,
	output pff_pkg::pff_status_t             st,
	output logic                             done,
	output logic                             fault,
	output logic [pff_pkg::RES_W-1:0]        evicted_count,
	output logic [pff_pkg::RES_W-1:0]        resident_count,
	output logic                             table_full,
	output logic [pff_pkg::FAULT_W-1:0]      fault_total
);

	localparam int KEY_W = (PAGE_BITS < pff_pkg::PAGE_IN_W) ? PAGE_BITS : pff_pkg::PAGE_IN_W;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [KEY_W-1:0] mem [TABLE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;
	logic [KEY_W-1:0] pg_q;
	logic [KEY_W-1:0] wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic [TABLE_DEPTH-1:0]     use_q;
	logic [CNT_W-1:0]           occ_q;
	logic [CNT_W-1:0]           idx_q;
	logic [CNT_W-1:0]           kept_q;
	logic [CNT_W-1:0]           evict_q;
	logic [CNT_W-1:0]           idx_prev;
	logic [CNT_W-1:0]           kept_d;
	logic                       chk_q;
	logic                       keep_now;
	logic                       room;
	logic [pff_pkg::GAP_W-1:0]  gap_q;
	logic [pff_pkg::THR_W-1:0]  thr_q;
	logic [pff_pkg::FAULT_W-1:0] fault_q;

	logic                       done_q;
	logic                       fault_res_q;
	logic [CNT_W-1:0]           evict_res_q;
	logic [CNT_W-1:0]           occ_res_q;
	logic                       full_res_q;
	logic [pff_pkg::FAULT_W-1:0] total_res_q;
	logic [CNT_W+pff_pkg::RES_W-1:0] evict_ext;
	logic [CNT_W+pff_pkg::RES_W-1:0] occ_ext;

	assign idx_prev = idx_q - 1'b1;
	assign keep_now = chk_q && use_q[idx_prev[IDX_W-1:0]];
	assign kept_d   = kept_q + CNT_W'(keep_now);
	assign room     = (occ_q < DEPTH_C);

	assign st.match        = chk_q && (rd_data_q == pg_q);
	assign st.at_end       = (idx_q == occ_q);
	assign st.evict_needed = (gap_q > thr_q);

	// one write port: compaction copy or final insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = occ_q[IDX_W-1:0];
		wr_data = pg_q;
		if (cmd.compact && keep_now) begin
			wr_en   = 1'b1;
			wr_addr = kept_q[IDX_W-1:0];
			wr_data = rd_data_q;
		end else if (cmd.finish && room) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pg_q <= page_number[KEY_W-1:0];
		end
		if (cmd.hit) begin
			fault_res_q <= 1'b0;
			evict_res_q <= '0;
			occ_res_q   <= occ_q;
			full_res_q  <= 1'b0;
			total_res_q <= fault_q;
		end else if (cmd.finish) begin
			fault_res_q <= 1'b1;
			evict_res_q <= evict_q;
			occ_res_q   <= room ? occ_q + 1'b1 : occ_q;
			full_res_q  <= !room;
			total_res_q <= fault_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q   <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
			kept_q  <= '0;
			evict_q <= '0;
			chk_q   <= 1'b0;
			gap_q   <= '0;
			thr_q   <= pff_pkg::THR_RESET;
			fault_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.hit || cmd.finish;
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				chk_q   <= 1'b0;
				kept_q  <= '0;
				evict_q <= '0;
				if (gap_q != '1) begin
					gap_q <= gap_q + 1'b1;
				end
			end
			if (cmd.scan && !cmd.hit && !cmd.miss) begin
				idx_q <= idx_q + 1'b1;
				chk_q <= 1'b1;
			end
			if (cmd.hit) begin
				use_q[idx_prev[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.miss) begin
				idx_q <= '0;
				chk_q <= 1'b0;
				if (fault_q != '1) begin
					fault_q <= fault_q + 1'b1;
				end
			end
			if (cmd.compact) begin
				kept_q <= kept_d;
				if (chk_q && !keep_now) begin
					evict_q <= evict_q + 1'b1;
				end
				if (!cmd.compact_done) begin
					idx_q <= idx_q + 1'b1;
					chk_q <= 1'b1;
				end else begin
					occ_q <= kept_d;
				end
			end
			if (cmd.finish) begin
				gap_q <= '0;
				// all use bits clear; the inserted page, if there was room, is marked
				use_q <= room ? (TABLE_DEPTH'(1) << occ_q[IDX_W-1:0]) : '0;
				if (room) begin
					occ_q <= occ_q + 1'b1;
				end
			end
		end
	end

	// counts narrower or wider than the result field
	assign evict_ext = {{pff_pkg::RES_W{1'b0}}, evict_res_q};
	assign occ_ext   = {{pff_pkg::RES_W{1'b0}}, occ_res_q};

	assign done           = done_q;
	assign fault          = fault_res_q;
	assign evicted_count  = evict_ext[pff_pkg::RES_W-1:0];
	assign resident_count = occ_ext[pff_pkg::RES_W-1:0];
	assign table_full     = full_res_q;
	assign fault_total    = total_res_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("occupancy beyond table depth");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !fault_res_q |-> evict_res_q == '0 && !full_res_q)
		else $error("hit result carries eviction or full flag");

	a_compact_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compact && chk_q |-> kept_q + evict_q + 1'b1 == idx_q)
		else $error("compaction lost track of entries");

	a_finish_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> gap_q == '0)
		else $error("gap not restarted after fault");

endmodule
